[rtl/core/gha_pkg.sv]
package gha_pkg;

	localparam int FUNC_W   = 2;
	localparam int IDX_W    = 12;
	localparam int GEN_W    = 8;
	localparam int THR_W    = 11;
	localparam int STATUS_W = 2;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 11'd500;

	localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ALIVE   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RING_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNALLOCATED = 2'd3;

	typedef enum logic [2:0] {
		K_NOP,
		K_REUSE,
		K_NEW,
		K_NOSLOT,
		K_DESTROY,
		K_ALIVE,
		K_UNALLOC
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic     busy;
		kind_t    kind;
	} dp_status_t;

endpackage

[rtl/core/gha_datapath.sv]
module gha_datapath #(
	parameter int SLOT_COUNT      = 4096,
	parameter int FREE_RING_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gha_pkg::dp_cmd_t                  cmd,
	output gha_pkg::dp_status_t               stat,
	input  logic                              cfg_valid,
	input  logic [gha_pkg::THR_W-1:0]         cfg_data,
	input  logic [gha_pkg::FUNC_W-1:0]        func,
	input  logic [gha_pkg::IDX_W-1:0]         slot_index,
	input  logic [gha_pkg::GEN_W-1:0]         slot_generation,
	output logic [gha_pkg::IDX_W-1:0]         new_index,
	output logic [gha_pkg::GEN_W-1:0]         new_generation,
	output logic                              is_alive,
	output logic [gha_pkg::STATUS_W-1:0]      status
);
	import gha_pkg::*;

	localparam int SA_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SC_W  = $clog2(SLOT_COUNT + 1);
	localparam int RA_W  = (FREE_RING_DEPTH > 1) ? $clog2(FREE_RING_DEPTH) : 1;
	localparam int RC_W  = $clog2(FREE_RING_DEPTH + 1);
	localparam int CMP_W = (SC_W > IDX_W) ? SC_W : IDX_W;
	localparam int RT_W  = (RC_W > THR_W) ? RC_W : THR_W;

	logic [GEN_W-1:0] gen_mem [SLOT_COUNT];
	logic [SA_W-1:0]  ring_mem [FREE_RING_DEPTH];

	logic [THR_W-1:0] thr_q;
	logic [SC_W-1:0]  slots_q;
	logic [RA_W-1:0]  head_q;
	logic [RC_W-1:0]  count_q;

	kind_t            kind_q;
	logic [IDX_W-1:0] idx_q;
	logic [GEN_W-1:0] gen_q;
	logic [SA_W-1:0]  ring_rd_q;
	logic [GEN_W-1:0] gen_rd_q;

	logic [IDX_W-1:0]    new_index_q;
	logic [GEN_W-1:0]    new_generation_q;
	logic                is_alive_q;
	logic [STATUS_W-1:0] status_q;

	logic [IDX_W-1:0]    new_index_d;
	logic [GEN_W-1:0]    new_generation_d;
	logic                is_alive_d;
	logic [STATUS_W-1:0] status_d;

	kind_t            kind_d;
	logic [CMP_W-1:0] slots_ext;
	logic [CMP_W-1:0] in_idx_ext;
	logic [CMP_W-1:0] idx_ext;
	logic [CMP_W-1:0] ring_slot_ext;
	logic [SA_W-1:0]  idx_slot;
	logic [SA_W-1:0]  gen_raddr;
	logic [RC_W:0]    tail_sum;
	logic [RA_W-1:0]  tail;
	logic [RA_W-1:0]  head_next;
	logic             reuse_ok;
	logic             ring_full;

	assign slots_ext     = CMP_W'(slots_q);
	assign in_idx_ext    = CMP_W'(slot_index);
	assign idx_ext       = CMP_W'(idx_q);
	assign ring_slot_ext = CMP_W'(ring_rd_q);
	assign idx_slot      = idx_ext[SA_W-1:0];
	assign reuse_ok      = RT_W'(count_q) > RT_W'(thr_q);
	assign ring_full     = count_q == RC_W'(FREE_RING_DEPTH);

	// ring tail, head + count stays below twice the depth
	assign tail_sum = (RC_W+1)'(head_q) + (RC_W+1)'(count_q);
	always_comb begin
		if (tail_sum >= (RC_W+1)'(FREE_RING_DEPTH)) begin
			tail = RA_W'(tail_sum - (RC_W+1)'(FREE_RING_DEPTH));
		end else begin
			tail = RA_W'(tail_sum);
		end
	end

	assign head_next = (head_q == RA_W'(FREE_RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign gen_raddr = (kind_q == K_REUSE) ? ring_rd_q : idx_slot;

	always_comb begin
		kind_d = K_NOP;
		unique case (func)
			FUNC_CREATE: begin
				if (reuse_ok) begin
					kind_d = K_REUSE;
				end else if (slots_q < SC_W'(SLOT_COUNT)) begin
					kind_d = K_NEW;
				end else begin
					kind_d = K_NOSLOT;
				end
			end
			FUNC_DESTROY: begin
				kind_d = (in_idx_ext >= slots_ext) ? K_UNALLOC : K_DESTROY;
			end
			FUNC_ALIVE: begin
				kind_d = (in_idx_ext >= slots_ext) ? K_UNALLOC : K_ALIVE;
			end
			default: begin
				kind_d = K_NOP;
			end
		endcase
	end

	assign stat.busy = (kind_q != K_NOP);
	assign stat.kind = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THRESHOLD_RESET;
			slots_q <= '0;
			head_q  <= '0;
			count_q <= '0;
			kind_q  <= K_NOP;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (cmd.load) begin
				kind_q <= kind_d;
			end
			if (cmd.commit) begin
				unique case (kind_q)
					K_REUSE: begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
					end
					K_NEW: begin
						slots_q <= slots_q + 1'b1;
					end
					K_DESTROY: begin
						if (!ring_full) begin
							count_q <= count_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= slot_index;
			gen_q <= slot_generation;
		end
		ring_rd_q <= ring_mem[head_q];
		gen_rd_q  <= gen_mem[gen_raddr];
		if (cmd.commit) begin
			unique case (kind_q)
				K_NEW: begin
					gen_mem[slots_q[SA_W-1:0]] <= '0;
				end
				K_DESTROY: begin
					gen_mem[idx_slot] <= gen_rd_q + 1'b1;
					if (!ring_full) begin
						ring_mem[tail] <= idx_slot;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		new_index_d      = '0;
		new_generation_d = '0;
		is_alive_d       = 1'b0;
		status_d         = ST_OK;
		unique case (kind_q)
			K_REUSE: begin
				new_index_d      = ring_slot_ext[IDX_W-1:0];
				new_generation_d = gen_rd_q;
			end
			K_NEW: begin
				new_index_d = slots_ext[IDX_W-1:0];
			end
			K_NOSLOT: begin
				status_d = ST_NO_SLOT;
			end
			K_DESTROY: begin
				status_d = ring_full ? ST_RING_FULL : ST_OK;
			end
			K_ALIVE: begin
				is_alive_d = (gen_rd_q == gen_q);
			end
			K_UNALLOC: begin
				status_d = ST_UNALLOCATED;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			new_index_q      <= new_index_d;
			new_generation_q <= new_generation_d;
			is_alive_q       <= is_alive_d;
			status_q         <= status_d;
		end
	end

	assign new_index      = new_index_q;
	assign new_generation = new_generation_q;
	assign is_alive       = is_alive_q;
	assign status         = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RC_W'(FREE_RING_DEPTH))
		else $error("free ring count beyond depth");

	a_slots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slots_q <= SC_W'(SLOT_COUNT))
		else $error("allocated slots beyond slot count");

	a_reuse_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && kind_q == K_REUSE |=> count_q == $past(count_q) - 1'b1)
		else $error("reuse did not pop the free ring");

endmodule

[rtl/core/gha_ctrl.sv]
module gha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  gha_pkg::dp_status_t stat,
	output gha_pkg::dp_cmd_t    cmd
);
	import gha_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_load_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_READ)
		else $error("accepted transfer did not start a read");

	a_read_to_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_COMMIT)
		else $error("read not followed by commit");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q && state_q == S_IDLE)
		else $error("commit did not present a result");

	a_nop_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !stat.busy |-> stat.kind == K_NOP)
		else $error("idle kind reported busy");

endmodule

[rtl/core/generational_handle_allocator.sv]
// generational handle allocator
// handles are a slot index plus an 8-bit generation. three valid/ready
// channels: the input carries func, slot_index and slot_generation; the
// output carries new_index, new_generation, is_alive and status; the cfg
// channel writes reuse_threshold and is always ready.
// func create takes the oldest freed slot once more than reuse_threshold
// slots are queued in the free ring, otherwise a fresh slot with generation
// zero while slots remain. destroy bumps the generation and queues the slot
// when the ring has room; alive compares handle and stored generation.
// every input transfer gives exactly one result transfer.
// an input transfer loads the request; the read step reads the
// generation memory (the free ring head is read at the transfer edge)
// and the commit step registers the result. one item is worked at a time
// and the idle state takes the next transfer once the last has committed.
// a new input is taken while an earlier result still waits at the output.
// when the receiver stalls, the next result holds in the commit step until
// the output register is free; input stays ready until a transfer is taken.
// reset clears counters, ring pointers and the threshold (back to 500);
// memory contents are not cleared and no clearing pass is needed.
module generational_handle_allocator #(
	parameter int SLOT_COUNT      = 4096,
	parameter int FREE_RING_DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gha_pkg::THR_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [gha_pkg::FUNC_W-1:0]       func,
	input  logic [gha_pkg::IDX_W-1:0]        slot_index,
	input  logic [gha_pkg::GEN_W-1:0]        slot_generation,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [gha_pkg::IDX_W-1:0]        new_index,
	output logic [gha_pkg::GEN_W-1:0]        new_generation,
	output logic                             is_alive,
	output logic [gha_pkg::STATUS_W-1:0]     status
);
	import gha_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t stat;

	assign cfg_ready = 1'b1;

	gha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gha_datapath #(
		.SLOT_COUNT      (SLOT_COUNT),
		.FREE_RING_DEPTH (FREE_RING_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.func            (func),
		.slot_index      (slot_index),
		.slot_generation (slot_generation),
		.new_index       (new_index),
		.new_generation  (new_generation),
		.is_alive        (is_alive),
		.status          (status)
	);

endmodule

[dv/generational_handle_allocator_tb.sv]
`timescale 1ns / 100ps

module generational_handle_allocator_tb;
	import gha_pkg::*;

	localparam int SLOTS        = 4096;
	localparam int RING_DEPTH   = 1024;
	localparam int CLK_PERIOD   = 12;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT  = 1000;
	localparam int PRINT_LIMIT  = 50;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [IDX_W-1:0]    index;
		logic [GEN_W-1:0]    generation;
		logic                alive;
		logic [STATUS_W-1:0] status;
	} handle_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [THR_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [FUNC_W-1:0]   func;
	logic [IDX_W-1:0]    slot_index;
	logic [GEN_W-1:0]    slot_generation;
	logic                out_valid;
	logic                out_ready;
	logic [IDX_W-1:0]    new_index;
	logic [GEN_W-1:0]    new_generation;
	logic                is_alive;
	logic [STATUS_W-1:0] status;

	// shadow of the allocator state
	bit [GEN_W-1:0]   gen_table [SLOTS];
	bit [IDX_W-1:0]   freed_slots [RING_DEPTH];
	int unsigned      ring_rd;
	int unsigned      ring_queued;
	int unsigned      slots_used;
	logic [THR_W-1:0] reuse_thr;

	handle_result_t pending_results[$];

	int error_count;
	int op_count;
	int fresh_count;
	int reused_count;
	int live_hits;
	int no_slot_count;
	int ring_full_count;
	int unalloc_count;
	int thr_writes;
	int quiet_cycles;
	int rx_wait;
	bit tx_burst;
	bit rx_burst;

	generational_handle_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.slot_index      (slot_index),
		.slot_generation (slot_generation),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.new_index       (new_index),
		.new_generation  (new_generation),
		.is_alive        (is_alive),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic handle_result_t predict_handle_op(input logic [FUNC_W-1:0] f,
			input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] g);
		handle_result_t r;
		int unsigned slot;
		r.index      = '0;
		r.generation = '0;
		r.alive      = 1'b0;
		r.status     = ST_OK;
		case (f)
		FUNC_CREATE: begin
			if (ring_queued > reuse_thr) begin
				slot = 32'(freed_slots[ring_rd]);
				ring_rd = (ring_rd + 1) % RING_DEPTH;
				ring_queued--;
				reused_count++;
			end else if (slots_used < SLOTS) begin
				slot = slots_used;
				gen_table[slot] = '0;
				slots_used++;
				fresh_count++;
			end else begin
				r.status = ST_NO_SLOT;
				no_slot_count++;
				return r;
			end
			r.index      = IDX_W'(slot);
			r.generation = gen_table[slot];
		end
		FUNC_DESTROY, FUNC_ALIVE: begin
			if (idx >= slots_used) begin
				r.status = ST_UNALLOCATED;
				unalloc_count++;
			end else if (f == FUNC_ALIVE) begin
				r.alive = (gen_table[idx] == g);
				if (r.alive)
					live_hits++;
			end else begin
				gen_table[idx] = gen_table[idx] + 1'b1;
				if (ring_queued < RING_DEPTH) begin
					freed_slots[(ring_rd + ring_queued) % RING_DEPTH] = idx;
					ring_queued++;
				end else begin
					// slot dropped, generation still bumped
					r.status = ST_RING_FULL;
					ring_full_count++;
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic send_handle_op(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
			input logic [GEN_W-1:0] g);
		int gap;
		if ($urandom_range(0, 49) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		func            <= f;
		slot_index      <= idx;
		slot_generation <= g;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(predict_handle_op(f, idx, g));
		op_count++;
	endtask

	task automatic send_random_op(input int pct_create, input int pct_destroy,
			input int pct_alive);
		int pick;
		logic [FUNC_W-1:0] f;
		logic [IDX_W-1:0]  idx;
		logic [GEN_W-1:0]  g;
		pick = $urandom_range(0, 99);
		if (pick < pct_create)
			f = FUNC_CREATE;
		else if (pick < pct_create + pct_destroy)
			f = FUNC_DESTROY;
		else if (pick < pct_create + pct_destroy + pct_alive)
			f = FUNC_ALIVE;
		else
			f = FUNC_UNUSED;
		if (slots_used > 0 && $urandom_range(0, 9) < 8)
			idx = IDX_W'($urandom_range(0, slots_used - 1));
		else
			idx = IDX_W'($urandom);
		if (idx < slots_used && $urandom_range(0, 2) != 0) begin
			g = gen_table[idx];
			// stale handle, one generation behind
			if ($urandom_range(0, 3) == 0)
				g = g - 1'b1;
		end else begin
			g = GEN_W'($urandom);
		end
		send_handle_op(f, idx, g);
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reuse_threshold(input logic [THR_W-1:0] value);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		reuse_thr = value;
		thr_writes++;
	endtask

	task automatic test_directed();
		send_handle_op(FUNC_ALIVE, '0, '0);
		send_handle_op(FUNC_DESTROY, '1, '0);
		send_handle_op(FUNC_UNUSED, '1, '1);
		repeat (3) send_handle_op(FUNC_CREATE, '0, '0);
		send_handle_op(FUNC_ALIVE, 12'd0, 8'd0);
		send_handle_op(FUNC_ALIVE, 12'd1, '1);
		send_handle_op(FUNC_DESTROY, 12'd1, '0);
		send_handle_op(FUNC_ALIVE, 12'd1, 8'd0);
		send_handle_op(FUNC_ALIVE, 12'd1, 8'd1);
		send_handle_op(FUNC_DESTROY, 12'd1, '0);
		send_handle_op(FUNC_ALIVE, 12'd1, 8'd2);
		send_handle_op(FUNC_ALIVE, 12'd3, 8'd0);
		send_handle_op(FUNC_DESTROY, 12'd2, '1);
		// queued slots below threshold, so a fresh slot
		send_handle_op(FUNC_CREATE, '1, '1);
		send_handle_op(FUNC_ALIVE, '1, '1);
		settle_idle();
	endtask

	task automatic test_low_threshold();
		write_reuse_threshold('0);
		repeat (80) send_random_op(35, 35, 25);
	endtask

	task automatic test_ring_full();
		write_reuse_threshold(11'd1024);
		// generation wraps past 255
		repeat (260) send_handle_op(FUNC_DESTROY, 12'd0, '0);
		send_handle_op(FUNC_ALIVE, 12'd0, gen_table[0]);
		while (ring_queued < RING_DEPTH)
			send_handle_op(FUNC_DESTROY, IDX_W'($urandom_range(0, slots_used - 1)), '0);
		repeat (20) send_random_op(5, 85, 10);
		write_reuse_threshold(11'd1023);
		repeat (60) send_random_op(50, 30, 15);
	endtask

	task automatic test_threshold_sweep();
		repeat (3) begin
			write_reuse_threshold(THR_W'($urandom_range(0, RING_DEPTH)));
			repeat (25) send_random_op(45, 35, 15);
		end
	endtask

	always @(posedge clk) begin : result_sink
		handle_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(status), 0);
			end else begin
				want = pending_results.pop_front();
				if (new_index !== want.index)
					report_mismatch("new_index", 32'(new_index), 32'(want.index));
				if (new_generation !== want.generation)
					report_mismatch("new_generation", 32'(new_generation),
						32'(want.generation));
				if (is_alive !== want.alive)
					report_mismatch("is_alive", 32'(is_alive), 32'(want.alive));
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
			end
			if ($urandom_range(0, 49) == 0)
				rx_burst = !rx_burst;
			rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
			out_ready <= (rx_wait == 0);
		end else if (!out_ready) begin
			if (rx_wait > 0)
				rx_wait--;
			if (rx_wait == 0)
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] timeout: no transfer for %0d cycles, %0d results pending",
				$time, quiet_cycles, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		func            = FUNC_CREATE;
		slot_index      = '0;
		slot_generation = '0;
		out_ready       = 1'b0;
		ring_rd         = 0;
		ring_queued     = 0;
		slots_used      = 0;
		reuse_thr       = THRESHOLD_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_low_threshold();
		test_ring_full();
		test_threshold_sweep();
		settle_idle();

		$display("%0d operations: %0d fresh slots, %0d reused slots, %0d live handle matches",
			op_count, fresh_count, reused_count, live_hits);
		$display("%0d out of slots, %0d ring full, %0d unallocated, %0d threshold writes",
			no_slot_count, ring_full_count, unalloc_count, thr_writes);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
